[src/pjvc_pkg.sv]
// Shared types, register indexes and fixed-point constants of the PID joint velocity controller.
`timescale 1ns / 1ps

package pjvc_pkg;

	// Fixed-point format of positions, gains and velocities.
	localparam int Q_W    = 32;
	localparam int FRAC_W = 16;
	localparam int VMAX_W = 31;

	typedef logic signed [Q_W-1:0] q16_t;
	typedef logic        [2:0]     joint_t;
	typedef logic        [2:0]     reg_idx_t;

	// Width of a product after the fraction shift, and of the summed velocity.
	typedef logic signed [2*Q_W-FRAC_W-1:0] term_t;
	typedef logic signed [2*Q_W-FRAC_W:0]   dterm_t;
	typedef logic signed [2*Q_W-FRAC_W+1:0] vsum_t;

	// Configuration register indexes.
	localparam reg_idx_t REG_P_GAIN       = 3'd0;
	localparam reg_idx_t REG_I_GAIN       = 3'd1;
	localparam reg_idx_t REG_D_GAIN       = 3'd2;
	localparam reg_idx_t REG_MAX_VELOCITY = 3'd3;
	localparam reg_idx_t REG_INTEGRAL_MAX = 3'd4;
	localparam reg_idx_t REG_INTEGRAL_MIN = 3'd5;

	// Limits of the signed Q16.16 range.
	localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
	localparam q16_t Q16_MIN = 32'sh8000_0000;
	localparam logic [VMAX_W-1:0] VMAX_RESET = 31'h7FFF_FFFF;

endpackage

[src/pid_joint_velocity_controller_unit.sv]
// Top level of the PID joint velocity controller with integrator anti-windup.
//
// Channel   Handshake             Payload
// config    cfg_we                cfg_index, cfg_wdata
// request   in_valid / in_stall   joint, target_position, measured_position
// result    out_valid / out_stall joint_out, velocity
//
// One request is accepted per clock cycle while in_stall is low; its result then passes through the
// stage-two, stage-three and output registers before it reaches the outputs.
// The stages are: input register, error and integrator update, three multipliers, sum and limit.
// Joint state is read and written in the second stage, so requests for one joint may follow
// each other in consecutive cycles. Reset clears gains, integrators and previous errors; limits go to maximum.
// A stalled result holds; empty stages still fill, and in_stall rises once all stages are full.
`timescale 1ns / 1ps

module pid_joint_velocity_controller_unit #(
	parameter int NUM_JOINTS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  pjvc_pkg::reg_idx_t   cfg_index,
	input  logic [31:0]          cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pjvc_pkg::joint_t     joint,
	input  pjvc_pkg::q16_t       target_position,
	input  pjvc_pkg::q16_t       measured_position,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pjvc_pkg::joint_t     joint_out,
	output pjvc_pkg::q16_t       velocity
);

	localparam int IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

	// Configuration registers.
	pjvc_pkg::q16_t                     p_gain_q;
	pjvc_pkg::q16_t                     i_gain_q;
	pjvc_pkg::q16_t                     d_gain_q;
	logic [pjvc_pkg::VMAX_W-1:0]        max_velocity_q;
	pjvc_pkg::q16_t                     integral_max_q;
	pjvc_pkg::q16_t                     integral_min_q;

	// Per-joint state.
	pjvc_pkg::q16_t integrator_q     [NUM_JOINTS];
	pjvc_pkg::q16_t previous_error_q [NUM_JOINTS];

	// Pipeline registers.
	logic              valid_s1, valid_s2, valid_s3, out_valid_q;
	pjvc_pkg::joint_t  joint_s1, joint_s2, joint_s3, joint_out_q;
	pjvc_pkg::q16_t    target_s1, measured_s1;
	pjvc_pkg::q16_t    err_s2, acc_s2;
	logic signed [32:0] diff_s2;
	logic              in_range_s2, in_range_s3;
	pjvc_pkg::term_t   p_term_s3, i_term_s3;
	pjvc_pkg::dterm_t  d_term_s3;
	pjvc_pkg::q16_t    velocity_q;

	// Flow control: a stage takes a new request when it is empty or moves on.
	logic out_ready, ready_s3, ready_s2, ready_s1, advance_s1;

	assign out_ready  = !out_valid_q || !out_stall;
	assign ready_s3   = !valid_s3 || out_ready;
	assign ready_s2   = !valid_s2 || ready_s3;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign advance_s1 = valid_s1 && ready_s2;
	assign in_stall   = !ready_s1;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q       <= '0;
			i_gain_q       <= '0;
			d_gain_q       <= '0;
			max_velocity_q <= pjvc_pkg::VMAX_RESET;
			integral_max_q <= pjvc_pkg::Q16_MAX;
			integral_min_q <= pjvc_pkg::Q16_MIN;
		end else if (cfg_we) begin
			case (cfg_index)
				pjvc_pkg::REG_P_GAIN:       p_gain_q       <= cfg_wdata;
				pjvc_pkg::REG_I_GAIN:       i_gain_q       <= cfg_wdata;
				pjvc_pkg::REG_D_GAIN:       d_gain_q       <= cfg_wdata;
				pjvc_pkg::REG_MAX_VELOCITY: max_velocity_q <= cfg_wdata[pjvc_pkg::VMAX_W-1:0];
				pjvc_pkg::REG_INTEGRAL_MAX: integral_max_q <= cfg_wdata;
				pjvc_pkg::REG_INTEGRAL_MIN: integral_min_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage one: input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			joint_s1    <= joint;
			target_s1   <= target_position;
			measured_s1 <= measured_position;
		end
	end

	// Stage two: saturated error, clamped integrator and error difference.
	logic               in_range_s1;
	logic [IDX_W-1:0]   idx_s1;
	pjvc_pkg::q16_t     integ_rd, prev_rd, err_sat, acc_clamp;
	logic signed [32:0] err_wide, acc_wide, imax_ext, imin_ext, diff_wide;

	always_comb begin
		in_range_s1 = 32'(joint_s1) < NUM_JOINTS;
		idx_s1      = IDX_W'(joint_s1);
		integ_rd    = in_range_s1 ? integrator_q[idx_s1] : '0;
		prev_rd     = in_range_s1 ? previous_error_q[idx_s1] : '0;

		err_wide = {target_s1[31], target_s1} - {measured_s1[31], measured_s1};
		if (err_wide[32] != err_wide[31]) begin
			err_sat = err_wide[32] ? pjvc_pkg::Q16_MIN : pjvc_pkg::Q16_MAX;
		end else begin
			err_sat = err_wide[31:0];
		end

		// The upper clamp is checked first, so it wins when the limits cross.
		acc_wide = {integ_rd[31], integ_rd} + {err_sat[31], err_sat};
		imax_ext = {integral_max_q[31], integral_max_q};
		imin_ext = {integral_min_q[31], integral_min_q};
		if (acc_wide > imax_ext) begin
			acc_clamp = integral_max_q;
		end else if (acc_wide < imin_ext) begin
			acc_clamp = integral_min_q;
		end else begin
			acc_clamp = acc_wide[31:0];
		end

		diff_wide = {err_sat[31], err_sat} - {prev_rd[31], prev_rd};
	end

	// Joint state changes once per in-range request, as it leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_JOINTS; k++) begin
				integrator_q[k]     <= '0;
				previous_error_q[k] <= '0;
			end
		end else if (advance_s1 && in_range_s1) begin
			integrator_q[idx_s1]     <= acc_clamp;
			previous_error_q[idx_s1] <= err_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			joint_s2    <= joint_s1;
			in_range_s2 <= in_range_s1;
			err_s2      <= err_sat;
			acc_s2      <= acc_clamp;
			diff_s2     <= diff_wide;
		end
	end

	// Stage three: gain products; dropping the fraction bits rounds toward minus infinity.
	logic signed [63:0] p_prod, i_prod;
	logic signed [64:0] d_prod;

	always_comb begin
		p_prod = 64'(err_s2) * 64'(p_gain_q);
		i_prod = 64'(acc_s2) * 64'(i_gain_q);
		d_prod = 65'(diff_s2) * 65'(d_gain_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			joint_s3    <= joint_s2;
			in_range_s3 <= in_range_s2;
			p_term_s3   <= p_prod[63:pjvc_pkg::FRAC_W];
			i_term_s3   <= i_prod[63:pjvc_pkg::FRAC_W];
			d_term_s3   <= d_prod[64:pjvc_pkg::FRAC_W];
		end
	end

	// Output stage: exact sum of the three terms, then the velocity limit.
	pjvc_pkg::vsum_t vel_sum, vmax_pos, vmax_neg;
	pjvc_pkg::q16_t  vel_lim;

	always_comb begin
		vel_sum  = {{2{p_term_s3[47]}}, p_term_s3} + {{2{i_term_s3[47]}}, i_term_s3}
			+ {d_term_s3[48], d_term_s3};
		vmax_pos = {19'b0, max_velocity_q};
		vmax_neg = -vmax_pos;
		if (vel_sum > 0) begin
			vel_lim = (vel_sum > vmax_pos) ? vmax_pos[31:0] : vel_sum[31:0];
		end else begin
			vel_lim = (vel_sum < vmax_neg) ? vmax_neg[31:0] : vel_sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && out_ready) begin
			joint_out_q <= joint_s3;
			velocity_q  <= in_range_s3 ? vel_lim : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign joint_out = joint_out_q;
	assign velocity  = velocity_q;

endmodule

[src/pjvc_checker.sv]
// Port-level checker of the PID joint velocity controller and its bind statement.
`timescale 1ns / 1ps

module pjvc_checker #(
	parameter int NUM_JOINTS = 6
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input pjvc_pkg::joint_t joint_out,
	input pjvc_pkg::q16_t   velocity
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(velocity) && $stable(joint_out))
		else $error("stalled result changed");

	// A joint outside the configured range always yields zero velocity.
	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (32'(joint_out) >= NUM_JOINTS) |-> velocity == '0)
		else $error("out-of-range joint gave a nonzero velocity");

	// The limit is symmetric, so the most negative code never appears.
	a_vel_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> velocity != pjvc_pkg::Q16_MIN)
		else $error("velocity below the negative limit");

	// With no result waiting, the pipeline is free to take a request.
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("request stalled while the result side is empty");

	// An accepted request reaches the output when the result side does not stall.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("result missing after pipeline latency");

endmodule

bind pid_joint_velocity_controller_unit pjvc_checker #(
	.NUM_JOINTS(NUM_JOINTS)
) u_pjvc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.joint_out (joint_out),
	.velocity  (velocity)
);

[tb/sv/tb_pid_joint_velocity_controller_unit.sv]
// Self-checking testbench of the PID joint velocity controller with a random and directed stimulus.
`timescale 1ns / 1ps

module tb_pid_joint_velocity_controller_unit;

	localparam int NUM_JOINTS = 6;
	localparam int HOLD_CYCLES = 60;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_REQUESTS = 175;

	// Register indexes that map to no register; writes to them must be ignored.
	localparam pjvc_pkg::reg_idx_t REG_UNMAPPED_A = 3'd6;
	localparam pjvc_pkg::reg_idx_t REG_UNMAPPED_B = 3'd7;

	typedef struct {
		pjvc_pkg::joint_t joint;
		pjvc_pkg::q16_t   target;
		pjvc_pkg::q16_t   measured;
		int unsigned      gap;
		bit               drain;
	} joint_sample_t;

	typedef struct {
		pjvc_pkg::joint_t joint;
		pjvc_pkg::q16_t   velocity;
	} velocity_cmd_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_we = 1'b0;
	pjvc_pkg::reg_idx_t cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	pjvc_pkg::joint_t joint = '0;
	pjvc_pkg::q16_t   target_position = '0;
	pjvc_pkg::q16_t   measured_position = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	pjvc_pkg::joint_t joint_out;
	pjvc_pkg::q16_t   velocity;

	// Controller settings and per-joint state as the testbench sees them.
	pjvc_pkg::q16_t gain_p;
	pjvc_pkg::q16_t gain_i;
	pjvc_pkg::q16_t gain_d;
	logic [pjvc_pkg::VMAX_W-1:0] vel_max;
	pjvc_pkg::q16_t integ_hi;
	pjvc_pkg::q16_t integ_lo;
	pjvc_pkg::q16_t integ_acc [NUM_JOINTS];
	pjvc_pkg::q16_t last_err [NUM_JOINTS];

	joint_sample_t sample_q [$];
	velocity_cmd_t velocity_due [$];
	joint_sample_t cur;
	velocity_cmd_t want;

	bit req_taken = 1'b0;
	bit res_taken = 1'b0;
	bit offering = 1'b0;
	int unsigned send_wait = 0;
	int unsigned recv_wait = 0;
	int unsigned hold_left = 0;
	int unsigned hold_asked = 0;
	int unsigned hold_served = 0;
	bit stall_now;

	int unsigned cycle_count = 0;
	int unsigned accepted = 0;
	int unsigned results_seen = 0;
	int unsigned stall_cycles = 0;
	int unsigned cfg_writes = 0;
	int unsigned mismatches = 0;

	pid_joint_velocity_controller_unit #(
		.NUM_JOINTS(NUM_JOINTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.joint(joint),
		.target_position(target_position),
		.measured_position(measured_position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.joint_out(joint_out),
		.velocity(velocity)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Exact Q16.16 product, floored by the arithmetic shift.
	function automatic logic signed [79:0] q16_mul(logic signed [79:0] a, logic signed [79:0] b);
		return (a * b) >>> pjvc_pkg::FRAC_W;
	endfunction

	// Computes the velocity for one request and advances that joint's state.
	function automatic velocity_cmd_t pid_step(pjvc_pkg::joint_t j, pjvc_pkg::q16_t tgt,
		pjvc_pkg::q16_t meas);
		velocity_cmd_t cmd;
		logic signed [33:0] diff;
		logic signed [33:0] acc;
		logic signed [33:0] derr;
		logic signed [79:0] vel;
		logic signed [79:0] vlim;
		pjvc_pkg::q16_t err;
		cmd.joint = j;
		cmd.velocity = '0;
		if (j >= NUM_JOINTS) begin
			return cmd;
		end
		diff = 34'(tgt) - 34'(meas);
		if (diff > 34'(pjvc_pkg::Q16_MAX)) begin
			err = pjvc_pkg::Q16_MAX;
		end else if (diff < 34'(pjvc_pkg::Q16_MIN)) begin
			err = pjvc_pkg::Q16_MIN;
		end else begin
			err = diff[31:0];
		end
		// The upper clamp wins when the two limits cross.
		acc = 34'(integ_acc[j]) + 34'(err);
		if (acc > 34'(integ_hi)) begin
			acc = 34'(integ_hi);
		end else if (acc < 34'(integ_lo)) begin
			acc = 34'(integ_lo);
		end
		integ_acc[j] = acc[31:0];
		derr = 34'(err) - 34'(last_err[j]);
		last_err[j] = err;
		vel = q16_mul(80'(err), 80'(gain_p)) + q16_mul(80'(acc), 80'(gain_i))
			+ q16_mul(80'(derr), 80'(gain_d));
		vlim = 80'(vel_max);
		if (vel > 0) begin
			if (vel > vlim) begin
				vel = vlim;
			end
		end else if (vel < -vlim) begin
			vel = -vlim;
		end
		cmd.velocity = vel[31:0];
		return cmd;
	endfunction

	// Random Q16.16 word: the extremes, full range, or near zero.
	function automatic pjvc_pkg::q16_t rand_q16();
		case ($urandom_range(0, 7))
			0: begin
				return pjvc_pkg::Q16_MAX;
			end
			1: begin
				return pjvc_pkg::Q16_MIN;
			end
			2, 3: begin
				return $urandom;
			end
			default: begin
				return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
			end
		endcase
	endfunction

	// Request driver: offers queued requests after each one's own idle gap.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && req_taken) begin
				offering = 1'b0;
			end
			if (!offering && sample_q.size() != 0) begin
				if (!(sample_q[0].drain && velocity_due.size() != 0)) begin
					if (send_wait < sample_q[0].gap) begin
						send_wait++;
					end else begin
						cur = sample_q.pop_front();
						send_wait = 0;
						joint <= cur.joint;
						target_position <= cur.target;
						measured_position <= cur.measured;
						offering = 1'b1;
					end
				end
			end
			in_valid <= offering;
		end
	end

	// Result receiver: random stalls per result, plus long hold-offs on demand.
	always @(negedge clk) begin
		if (res_taken) begin
			recv_wait = (results_seen % 64 < 16) ? 0 : $urandom_range(0, 5);
		end
		if (hold_asked != hold_served) begin
			hold_left = HOLD_CYCLES;
			hold_served = hold_asked;
		end
		if (hold_left > 0) begin
			hold_left--;
			stall_now = 1'b1;
		end else if (recv_wait > 0) begin
			recv_wait--;
			stall_now = 1'b1;
		end else begin
			stall_now = 1'b0;
		end
		out_stall <= stall_now;
	end

	// Monitor: predicts on each accepted request and checks each accepted result.
	always @(posedge clk) begin
		req_taken <= in_valid && !in_stall;
		res_taken <= out_valid && !out_stall;
		if (arst_n) begin
			cycle_count++;
			if (in_valid && !in_stall) begin
				velocity_due.push_back(pid_step(joint, target_position, measured_position));
				accepted++;
			end
			if (in_valid && in_stall) begin
				stall_cycles++;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (velocity_due.size() == 0) begin
					$error("result with no request pending: joint_out %0d velocity %0d",
						joint_out, velocity);
					mismatches++;
				end else begin
					want = velocity_due.pop_front();
					if (joint_out !== want.joint) begin
						$error("joint_out mismatch: expected %0d, got %0d", want.joint, joint_out);
						mismatches++;
					end
					if (velocity !== want.velocity) begin
						$error("velocity mismatch: expected %0d, got %0d",
							want.velocity, velocity);
						mismatches++;
					end
				end
			end
			if (cycle_count > CYCLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Waits until every request has been sent and every result has come back.
	task automatic wait_idle();
		do begin
			@(negedge clk);
			#1;
		end while (sample_q.size() != 0 || offering || velocity_due.size() != 0);
	endtask

	task automatic write_reg(pjvc_pkg::reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			pjvc_pkg::REG_P_GAIN: begin
				gain_p = val;
			end
			pjvc_pkg::REG_I_GAIN: begin
				gain_i = val;
			end
			pjvc_pkg::REG_D_GAIN: begin
				gain_d = val;
			end
			pjvc_pkg::REG_MAX_VELOCITY: begin
				vel_max = val[pjvc_pkg::VMAX_W-1:0];
			end
			pjvc_pkg::REG_INTEGRAL_MAX: begin
				integ_hi = val;
			end
			pjvc_pkg::REG_INTEGRAL_MIN: begin
				integ_lo = val;
			end
			default: begin
			end
		endcase
		cfg_writes++;
	endtask

	// Writes all six registers and one unmapped index while the block is idle.
	task automatic apply_settings(pjvc_pkg::q16_t kp, pjvc_pkg::q16_t ki, pjvc_pkg::q16_t kd,
		logic [31:0] vmax, pjvc_pkg::q16_t ihi, pjvc_pkg::q16_t ilo);
		wait_idle();
		write_reg(pjvc_pkg::REG_P_GAIN, kp);
		write_reg(pjvc_pkg::REG_I_GAIN, ki);
		write_reg(pjvc_pkg::REG_D_GAIN, kd);
		write_reg(pjvc_pkg::REG_MAX_VELOCITY, vmax);
		write_reg(pjvc_pkg::REG_INTEGRAL_MAX, ihi);
		write_reg(pjvc_pkg::REG_INTEGRAL_MIN, ilo);
		write_reg($urandom_range(0, 1) ? REG_UNMAPPED_A : REG_UNMAPPED_B, $urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_sample(pjvc_pkg::joint_t j, pjvc_pkg::q16_t tgt, pjvc_pkg::q16_t meas,
		int unsigned gap, bit drain);
		joint_sample_t s;
		s.joint = j;
		s.target = tgt;
		s.measured = meas;
		s.gap = gap;
		s.drain = drain;
		sample_q.push_back(s);
	endtask

	// One phase of random settings followed by random requests.
	task automatic random_phase(int n, bit hold, bit drain_mid);
		pjvc_pkg::q16_t lim_a;
		pjvc_pkg::q16_t lim_b;
		pjvc_pkg::q16_t tgt;
		pjvc_pkg::q16_t meas;
		logic [31:0] vmax;
		pjvc_pkg::joint_t j;
		int unsigned gap;
		lim_a = rand_q16();
		lim_b = rand_q16();
		// Mostly ordered integrator limits, sometimes crossed.
		if (($urandom_range(0, 3) != 0) == (lim_a < lim_b)) begin
			{lim_a, lim_b} = {lim_b, lim_a};
		end
		case ($urandom_range(0, 4))
			0: begin
				vmax = '0;
			end
			1: begin
				vmax = 32'hFFFF_FFFF;
			end
			2: begin
				vmax = $urandom;
			end
			default: begin
				vmax = $urandom_range(0, 32'h000F_FFFF);
			end
		endcase
		apply_settings(rand_q16(), rand_q16(), rand_q16(), vmax, lim_a, lim_b);
		if (hold) begin
			hold_asked++;
		end
		for (int k = 0; k < n; k++) begin
			j = pjvc_pkg::joint_t'(($urandom_range(0, 9) == 0) ? $urandom_range(6, 7)
				: $urandom_range(0, 5));
			tgt = rand_q16();
			// Half the time the measurement tracks the target closely.
			if ($urandom_range(0, 1)) begin
				meas = tgt - ($signed($urandom_range(0, 32'h0000_FFFF)) - 32'sh0000_8000);
			end else begin
				meas = rand_q16();
			end
			gap = (hold || k % 40 < 10) ? 0 : $urandom_range(0, 5);
			queue_sample(j, tgt, meas, gap, drain_mid && k == n / 2);
		end
		wait_idle();
	endtask

	// Main sequence: reset, directed requests, then random phases.
	initial begin
		gain_p = '0;
		gain_i = '0;
		gain_d = '0;
		vel_max = pjvc_pkg::VMAX_RESET;
		integ_hi = pjvc_pkg::Q16_MAX;
		integ_lo = pjvc_pkg::Q16_MIN;
		for (int k = 0; k < NUM_JOINTS; k++) begin
			integ_acc[k] = '0;
			last_err[k] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero gains, but the integrators still accumulate.
		queue_sample(3'd0, 32'sh0003_0000, 32'sh0001_0000, $urandom_range(0, 5), 1'b0);
		queue_sample(3'd1, pjvc_pkg::Q16_MIN, 32'sh0000_0001, $urandom_range(0, 5), 1'b0);

		// Moderate gains and a tight integrator window.
		apply_settings(32'sh0001_0000, 32'sh0000_4000, 32'sh0000_8000, 32'h7FFF_FFFF,
			32'sh0010_0000, -32'sh0010_0000);
		queue_sample(3'd0, pjvc_pkg::Q16_MAX, pjvc_pkg::Q16_MIN, $urandom_range(0, 5), 1'b0);
		queue_sample(3'd0, pjvc_pkg::Q16_MIN, pjvc_pkg::Q16_MAX, $urandom_range(0, 5), 1'b0);
		queue_sample(3'd1, 32'sh0001_0000, 32'sh0000_0000, 0, 1'b0);
		queue_sample(3'd1, 32'sh0001_0000, 32'sh0000_0000, 0, 1'b0);
		queue_sample(3'd2, 32'sh0000_0000, 32'sh0000_0000, $urandom_range(0, 5), 1'b0);
		queue_sample(3'd3, 32'sh0000_0000, 32'sh0000_0003, $urandom_range(0, 5), 1'b0);
		queue_sample(3'd4, 32'sh0000_0001, 32'sh0000_0000, $urandom_range(0, 5), 1'b0);
		queue_sample(3'd5, 32'sh7FFF_0000, 32'sh7FFF_0000, $urandom_range(0, 5), 1'b0);
		queue_sample(3'd6, pjvc_pkg::Q16_MAX, pjvc_pkg::Q16_MIN, $urandom_range(0, 5), 1'b0);
		queue_sample(3'd7, 32'sh0000_0005, 32'sh0000_0003, $urandom_range(0, 5), 1'b0);
		queue_sample(3'd5, 32'sh0020_0000, 32'sh0000_0000, 0, 1'b0);
		queue_sample(3'd5, 32'sh0020_0000, 32'sh0000_0000, 0, 1'b0);

		// Extreme gains, crossed integrator limits and a small velocity limit.
		apply_settings(pjvc_pkg::Q16_MIN, pjvc_pkg::Q16_MAX, pjvc_pkg::Q16_MIN, 32'h0000_8000,
			-32'sh0001_0000, 32'sh0001_0000);
		queue_sample(3'd0, 32'sh0000_0100, 32'sh0000_0000, $urandom_range(0, 5), 1'b0);
		queue_sample(3'd1, 32'sh0000_0000, 32'sh0000_0100, $urandom_range(0, 5), 1'b0);
		queue_sample(3'd2, pjvc_pkg::Q16_MAX, pjvc_pkg::Q16_MIN, $urandom_range(0, 5), 1'b0);
		queue_sample(3'd3, pjvc_pkg::Q16_MIN, pjvc_pkg::Q16_MAX, $urandom_range(0, 5), 1'b0);

		// Zero velocity limit: both signs collapse to zero.
		apply_settings(32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000, 32'h0000_0000,
			pjvc_pkg::Q16_MAX, pjvc_pkg::Q16_MIN);
		queue_sample(3'd4, 32'sh0001_0000, 32'sh0000_0000, $urandom_range(0, 5), 1'b0);
		queue_sample(3'd4, 32'sh0000_0000, 32'sh0001_0000, $urandom_range(0, 5), 1'b0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_phase(PHASE_REQUESTS, p == 3, p == 5);
		end

		wait_idle();
		repeat (8) @(negedge clk);
		$display("Checked %0d velocity results from %0d requests across %0d register writes.",
			results_seen, accepted, cfg_writes);
		$display("Requests were held back by a full pipeline on %0d cycles.", stall_cycles);
		if (mismatches == 0 && velocity_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
